@@ src/xcafp_pkg.sv @@
package xcafp_pkg;

  localparam int unsigned NumFields = 6;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned FieldIdxW = 3;
  localparam logic [FieldIdxW-1:0] LastField = 3'd5;

  localparam logic [7:0] ChHeader = 8'h24;  // '$'
  localparam logic [7:0] ChStar   = 8'h2A;  // '*'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [7:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [7:0] ChSpace  = 8'h20;  // ' '
  localparam logic [7:0] ChLetO   = 8'h4F;  // 'O'
  localparam logic [7:0] ChLetF   = 8'h46;  // 'F'
  localparam logic [7:0] ChLetL   = 8'h4C;  // 'L'
  localparam logic [7:0] BadSum   = 8'hFF;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CHECK   = 3'b100
  } frame_phase_e;

  typedef enum logic [2:0] {
    NUM_SKIP   = 3'b001,
    NUM_DIGITS = 3'b010,
    NUM_DONE   = 3'b100
  } num_phase_e;

  typedef enum logic [1:0] {
    SUF_NONE = 2'd0,
    SUF_F    = 2'd1,
    SUF_L    = 2'd2
  } suffix_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes one ASCII hex digit of either case.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ src/xor_checked_ascii_frame_parser.sv @@
// Each accepted byte passes through the input register and then the result register.
// Throughput: one item per cycle unless a waiting result stalls the flow; the input
// and result registers let a new byte in while the previous result still waits.
// Reset (rst_ni low, asynchronous): the parser waits for a header, all shadow and held
// values and the target flag are zero, and neither register holds an item.
module xor_checked_ascii_frame_parser
  import xcafp_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_accepted_o,
  output logic signed [15:0] position_o,
  output logic signed [15:0] velocity_o,
  output logic [7:0]         confidence_o,
  output logic [7:0]         status_flags_o,
  output logic [15:0]        age_o,
  output logic [15:0]        sequence_res_o,
  output logic               target_hit_o
);

  // The payload counter must be able to hold PAYLOAD_MAX itself.
  localparam int unsigned CountW = $clog2(PAYLOAD_MAX + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(PAYLOAD_MAX);

  // Input register: the byte waits here until the result register is free.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // Result register: only the accept flag is stored; the held values are themselves
  // registers that move only when a result is loaded, so they always match the result
  // item on show.
  logic out_valid_q, out_valid_d;
  logic accepted_q, accepted_d;

  // Parser state.
  frame_phase_e            phase_q, phase_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [7:0]              xor_q, xor_d;
  logic [7:0]              first_chk_q, first_chk_d;
  logic                    chk_cnt_q, chk_cnt_d;
  logic                    lead_ok_q, lead_ok_d;
  logic [FieldIdxW-1:0]    field_q, field_d;
  num_phase_e              num_phase_q, num_phase_d;
  logic                    neg_q, neg_d;
  logic [FieldW-1:0]       acc_q, acc_d;
  suffix_e                 suffix_q, suffix_d;
  logic [FieldW-1:0]       shadow_q [NumFields];
  logic [FieldW-1:0]       shadow_d [NumFields];
  logic [FieldW-1:0]       held_q   [NumFields];
  logic [FieldW-1:0]       held_d   [NumFields];
  logic                    target_q, target_d;

  // Decode helpers for the byte being processed.
  logic [7:0]        b;
  logic              is_digit;
  logic              is_space;
  logic [FieldW-1:0] digit_val;
  logic [FieldW-1:0] acc_times10;
  logic [FieldW-1:0] shadow_val;
  hex_t              hi_nib, lo_nib;
  logic [7:0]        recv_sum;
  logic              sum_ok;

  // A byte moves from the input register into the parser whenever the result register
  // is empty or its item is being taken in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  assign b           = in_byte_q;
  assign is_digit    = (b >= 8'h30) && (b <= 8'h39);
  assign is_space    = (b == ChSpace) || ((b >= 8'd9) && (b <= 8'd13));
  assign digit_val   = FieldW'(b[3:0]);
  // Multiply by ten as a sum of two shifts; the result wraps to the field width.
  assign acc_times10 = {acc_q[FieldW-4:0], 3'b000} + {acc_q[FieldW-2:0], 1'b0};
  assign hi_nib      = hex_decode(first_chk_q);
  assign lo_nib      = hex_decode(b);
  assign recv_sum    = {hi_nib.val, lo_nib.val};
  // A received checksum of all ones is refused even when it matches.
  assign sum_ok      = hi_nib.ok && lo_nib.ok && (recv_sum != BadSum) && (recv_sum == xor_q);

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    xor_d       = xor_q;
    first_chk_d = first_chk_q;
    chk_cnt_d   = chk_cnt_q;
    lead_ok_d   = lead_ok_q;
    field_d     = field_q;
    num_phase_d = num_phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    suffix_d    = suffix_q;
    shadow_d    = shadow_q;
    held_d      = held_q;
    target_d    = target_q;
    accepted_d  = 1'b0;
    shadow_val  = '0;

    unique case (phase_q)
      PH_WAIT: begin
        // A header opens a new frame and clears everything that the frame builds up.
        if (b == ChHeader) begin
          phase_d     = PH_PAYLOAD;
          count_d     = '0;
          xor_d       = '0;
          chk_cnt_d   = 1'b0;
          lead_ok_d   = 1'b0;
          field_d     = '0;
          suffix_d    = SUF_NONE;
          num_phase_d = NUM_SKIP;
          neg_d       = 1'b0;
          acc_d       = '0;
          for (int i = 0; i < NumFields; i++) begin
            shadow_d[i] = '0;
          end
        end
      end

      PH_PAYLOAD: begin
        if (b == ChStar) begin
          phase_d   = PH_CHECK;
          chk_cnt_d = 1'b0;
        end else if (count_q < CountMax) begin
          xor_d   = xor_q ^ b;
          count_d = count_q + 1'b1;
          if (count_q == '0) begin
            lead_ok_d = (b == ChLetO);
          end else if (b == ChComma && field_q < LastField) begin
            // A separator moves to the next field and starts a fresh number there.
            field_d     = field_q + 1'b1;
            num_phase_d = NUM_SKIP;
            neg_d       = 1'b0;
            acc_d       = '0;
            for (int i = 0; i < NumFields; i++) begin
              if (FieldIdxW'(i) == field_q + 1'b1) begin
                shadow_d[i] = '0;
              end
            end
          end else begin
            // The first F or L in the last field decides the suffix.
            if (field_q == LastField && suffix_q == SUF_NONE) begin
              if (b == ChLetF) begin
                suffix_d = SUF_F;
              end else if (b == ChLetL) begin
                suffix_d = SUF_L;
              end
            end
            unique case (num_phase_q)
              NUM_SKIP: begin
                if (is_space) begin
                  num_phase_d = NUM_SKIP;
                end else if (b == ChPlus) begin
                  num_phase_d = NUM_DIGITS;
                end else if (b == ChMinus) begin
                  neg_d       = 1'b1;
                  num_phase_d = NUM_DIGITS;
                end else if (is_digit) begin
                  acc_d       = digit_val;
                  num_phase_d = NUM_DIGITS;
                end else begin
                  num_phase_d = NUM_DONE;
                end
              end
              NUM_DIGITS: begin
                if (is_digit) begin
                  acc_d = acc_times10 + digit_val;
                end else begin
                  num_phase_d = NUM_DONE;
                end
              end
              NUM_DONE: begin
                num_phase_d = NUM_DONE;
              end
              default: begin
                num_phase_d = NUM_DONE;
              end
            endcase
            shadow_val = neg_d ? (FieldW'(0) - acc_d) : acc_d;
            for (int i = 0; i < NumFields; i++) begin
              if (FieldIdxW'(i) == field_q) begin
                shadow_d[i] = shadow_val;
              end
            end
          end
        end else begin
          // Too long: the byte is dropped and the hunt for a header starts over.
          phase_d = PH_WAIT;
        end
      end

      PH_CHECK: begin
        if (!chk_cnt_q) begin
          first_chk_d = b;
          chk_cnt_d   = 1'b1;
        end else begin
          if (sum_ok) begin
            accepted_d = 1'b1;
            // When the payload began with O, fields up to the last one reached are committed;
            // the target flag only when the frame got as far as the last field.
            if (lead_ok_q) begin
              for (int i = 0; i < NumFields; i++) begin
                if (FieldIdxW'(i) <= field_q) begin
                  held_d[i] = shadow_q[i];
                end
              end
              if (field_q == LastField) begin
                target_d = (suffix_q == SUF_F) && shadow_q[3][0];
              end
            end
          end
          phase_d   = PH_WAIT;
          count_d   = '0;
          chk_cnt_d = 1'b0;
        end
      end

      default: begin
        phase_d = PH_WAIT;
      end
    endcase
  end

  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      phase_q     <= PH_WAIT;
      count_q     <= '0;
      xor_q       <= '0;
      first_chk_q <= '0;
      chk_cnt_q   <= 1'b0;
      lead_ok_q   <= 1'b0;
      field_q     <= '0;
      num_phase_q <= NUM_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      suffix_q    <= SUF_NONE;
      target_q    <= 1'b0;
      for (int i = 0; i < NumFields; i++) begin
        shadow_q[i] <= '0;
        held_q[i]   <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        accepted_q  <= accepted_d;
        phase_q     <= phase_d;
        count_q     <= count_d;
        xor_q       <= xor_d;
        first_chk_q <= first_chk_d;
        chk_cnt_q   <= chk_cnt_d;
        lead_ok_q   <= lead_ok_d;
        field_q     <= field_d;
        num_phase_q <= num_phase_d;
        neg_q       <= neg_d;
        acc_q       <= acc_d;
        suffix_q    <= suffix_d;
        target_q    <= target_d;
        shadow_q    <= shadow_d;
        held_q      <= held_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_accepted_o = accepted_q;
  assign position_o       = $signed(held_q[0]);
  assign velocity_o       = $signed(held_q[1]);
  assign confidence_o     = held_q[2][7:0];
  assign status_flags_o   = held_q[3][7:0];
  assign age_o            = held_q[4];
  assign sequence_res_o   = held_q[5];
  assign target_hit_o     = target_q;

`ifndef NO_ASSERTIONS
  // The held values and the target flag move only when a byte is processed.
  a_held_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(held_q[0]) && $stable(held_q[3]) && $stable(held_q[5])
                  && $stable(target_q)))
    else $error("held values changed without a processed byte");

  // An accepted frame always sends the parser back to hunting for a header.
  a_accept_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && accepted_d) |=> (phase_q == PH_WAIT))
    else $error("parser did not return to header hunt after an accepted frame");

  // The payload count never passes the limit and the field index stays in range.
  a_count_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CountMax) && (field_q <= LastField))
    else $error("payload count or field index out of range");

  // A result can only be loaded when the input register holds a byte.
  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || out_ready_i) && !in_valid_q |=> !out_valid_q)
    else $error("result appeared without an input byte");
`endif

endmodule
